// ----- sv/wfss_pkg.sv -----
`default_nettype none
package wfss_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned TW     = 16;  // time, id and burst fields
  localparam int unsigned PRIO_W = 10;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned VT_W   = 48;
  localparam int unsigned ORD_W  = 32;
  localparam int unsigned IDX_W  = 8;   // covers the largest table
  localparam int unsigned WGT_W  = 31;  // 100 << 24 fits at the widest fraction
  localparam int unsigned PROD_W = TW + WGT_W;

  localparam logic [TW-1:0]   SLICE_RST = 16'd10;
  localparam logic [VT_W-1:0] VT_MAX    = '1;

  localparam logic [ST_W-1:0] ST_ADMIT  = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd2;
  localparam logic [ST_W-1:0] ST_RUN    = 3'd3;
  localparam logic [ST_W-1:0] ST_FINISH = 3'd4;

  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [TW-1:0]     proc_id;
    logic [TW-1:0]     burst_time;
    logic [TW-1:0]     arrival_time;
    logic [PRIO_W-1:0] weight_priority;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [TW-1:0]   chosen_id;
    logic [TW-1:0]   start_time;
    logic [TW-1:0]   run_length;
    logic [TW-1:0]   left_after;
    logic [TW-1:0]   turnaround;
    logic [TW-1:0]   ready_wait;
    logic            all_done;
  } out_t;

  // token handed from cell to cell during a pass
  typedef struct packed {
    logic             live;
    logic             has;
    logic [IDX_W-1:0] idx;
    logic [TW-1:0]    id;
    logic [TW-1:0]    left;
    logic [TW-1:0]    burst;
    logic [TW-1:0]    arrival;
    logic [WGT_W-1:0] wgt;
    logic [VT_W-1:0]  vt;
    logic [ORD_W-1:0] order;
    logic [ORD_W-1:0] cnt;
  } tok_t;

  // broadcast to all cells while a pass runs
  typedef struct packed {
    logic             sched;
    logic [TW-1:0]    now;
    logic [TW-1:0]    id;
    logic [TW-1:0]    burst;
    logic [TW-1:0]    arrival;
    logic [WGT_W-1:0] wgt;
  } cmd_t;

  // write-back to the dispatched cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [TW-1:0]    left;
    logic [VT_W-1:0]  vt;
    logic             fin;
    logic [ORD_W-1:0] order;
  } wb_t;

endpackage
`default_nettype wire

// ----- sv/wfss_div.sv -----
`default_nettype none
module wfss_div #(
  parameter int unsigned FRAC_BITS = wfss_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [wfss_pkg::PRIO_W-1:0]  prio_i,
  output logic                              done_o,
  output logic [wfss_pkg::WGT_W-1:0]        quot_o
);
  import wfss_pkg::*;

  localparam int unsigned NB = 7 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NB);
  localparam logic [NB-1:0] DIVIDEND = NB'(100) << FRAC_BITS;

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [PRIO_W-1:0] div_q;
  logic [PRIO_W-1:0] rem_q;
  logic [NB-1:0]     quo_q;
  logic [CW-1:0]     bit_idx;
  logic [PRIO_W:0]   trial;
  logic              ge;

  assign bit_idx = CW'(NB - 1) - cnt_q;
  assign trial   = {rem_q, DIVIDEND[bit_idx]};
  assign ge      = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= (prio_i == '0) ? PRIO_W'(1) : prio_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? PRIO_W'(trial - {1'b0, div_q}) : PRIO_W'(trial);
      quo_q <= {quo_q[NB-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = WGT_W'(quo_q);

endmodule
`default_nettype wire

// ----- sv/wfss_cell.sv -----
`default_nettype none
module wfss_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wfss_pkg::cmd_t cmd_i,
  input  wire wfss_pkg::wb_t  wb_i,
  input  wire wfss_pkg::tok_t tok_i,
  output wfss_pkg::tok_t      tok_o
);
  import wfss_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             used_q, ready_q;
  logic [TW-1:0]    id_q, left_q, burst_q, arr_q;
  logic [WGT_W-1:0] wgt_q;
  logic [VT_W-1:0]  vt_q;
  logic [ORD_W-1:0] ord_q;
  logic             live_q;
  tok_t             tok_q, tok_d;

  logic             arrive, claim, better, rdy_eff, wb_hit;
  logic [ORD_W-1:0] ord_eff;

  assign arrive  = tok_i.live && cmd_i.sched && used_q && !ready_q && (arr_q <= cmd_i.now);
  assign claim   = tok_i.live && !cmd_i.sched && !tok_i.has && !used_q;
  assign ord_eff = arrive ? tok_i.cnt : ord_q;
  assign rdy_eff = ready_q | arrive;
  assign better  = used_q && rdy_eff &&
                   (!tok_i.has || (vt_q < tok_i.vt) ||
                    ((vt_q == tok_i.vt) && (ord_eff < tok_i.order)));
  assign wb_hit  = wb_i.en && (wb_i.idx == MY_IDX);

  always_comb begin
    tok_d     = tok_i;
    tok_d.cnt = tok_i.cnt + ORD_W'(arrive);
    if (cmd_i.sched && better) begin
      tok_d.has     = 1'b1;
      tok_d.idx     = MY_IDX;
      tok_d.id      = id_q;
      tok_d.left    = left_q;
      tok_d.burst   = burst_q;
      tok_d.arrival = arr_q;
      tok_d.wgt     = wgt_q;
      tok_d.vt      = vt_q;
      tok_d.order   = ord_eff;
    end
    if (claim) begin
      tok_d.has = 1'b1;
      tok_d.idx = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      ready_q <= 1'b0;
      live_q  <= 1'b0;
    end else begin
      live_q <= tok_d.live;
      if (claim) begin
        used_q  <= 1'b1;
        ready_q <= 1'b0;
      end else if (arrive) begin
        ready_q <= 1'b1;
      end else if (wb_hit && wb_i.fin) begin
        used_q  <= 1'b0;
        ready_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (claim) begin
      id_q    <= cmd_i.id;
      left_q  <= cmd_i.burst;
      burst_q <= cmd_i.burst;
      arr_q   <= cmd_i.arrival;
      wgt_q   <= cmd_i.wgt;
      vt_q    <= '0;
      ord_q   <= '0;
    end else if (arrive) begin
      ord_q <= tok_i.cnt;
    end else if (wb_hit) begin
      left_q <= wb_i.left;
      vt_q   <= wb_i.vt;
      if (!wb_i.fin) begin
        ord_q <= wb_i.order;
      end
    end
  end

  always_comb begin
    tok_o      = tok_q;
    tok_o.live = live_q;
  end

endmodule
`default_nettype wire

// ----- sv/weighted_fair_slice_scheduler.sv -----
// Weighted fair slice scheduler. Every process lives in one cell of a row of
// MAX_PROCS cells; a token walks the row one cell a clock. An admit item first
// forms the step weight floor(100 * 2^FRAC_BITS / priority), a priority of
// zero taken as one, in a bit-serial divider, then walks the row to claim the
// lowest free cell. A schedule item walks the row once, marking arrivals in
// cell order and carrying the least virtual runtime forward, then does the
// multiply in S_MUL and the saturating add and write-back in S_ADD; an idle
// tick, with no ready process, skips both. One item is in work at a time and
// the next can be taken from the cycle in which the result is presented. The
// result sits in an output register, so the next item is taken while the
// previous result still waits; a result that finds the register still
// occupied holds the block until it drains.
// slice_length may be written through cfg_we_i whenever the block is idle
// and reads as 10 after reset.
`default_nettype none
module weighted_fair_slice_scheduler #(
  parameter int unsigned MAX_PROCS = wfss_pkg::MAX_PROCS_DEF,
  parameter int unsigned FRAC_BITS = wfss_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire wfss_pkg::in_t        in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wfss_pkg::out_t            out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_data_i
);
  import wfss_pkg::*;

  localparam int unsigned UCW = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_q;
  logic [TW-1:0]    slice_q;
  logic [TW-1:0]    now_q;
  logic [ORD_W-1:0] counter_q;
  logic [UCW-1:0]   used_cnt_q;
  logic             inj_q;
  in_t              item_q;
  logic [WGT_W-1:0] wgt_q;
  tok_t             best_q;
  logic [TW-1:0]    run_q;
  logic [PROD_W-1:0] prod_q;
  out_t             res_q, out_q;
  logic             out_valid_q;

  tok_t             tok [MAX_PROCS+1];
  cmd_t             cmd;
  wb_t              wb;

  logic             div_start, div_done;
  logic [WGT_W-1:0] div_quot;
  logic             accept, pass_end, out_load;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign pass_end   = tok[MAX_PROCS].live;
  assign div_start  = accept && (in_data_i.opcode == OP_ADMIT);
  // move a finished result into the output register once it is free
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  wfss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .prio_i  (in_data_i.weight_priority),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // inject the token at the head of the row
  always_comb begin
    tok[0]      = '0;
    tok[0].live = inj_q;
    tok[0].cnt  = counter_q;
  end

  assign cmd.sched   = item_q.opcode;
  assign cmd.now     = now_q;
  assign cmd.id      = item_q.proc_id;
  assign cmd.burst   = item_q.burst_time;
  assign cmd.arrival = item_q.arrival_time;
  assign cmd.wgt     = wgt_q;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    wfss_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .wb_i   (wb),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // dispatch arithmetic
  logic [TW-1:0]     quantum, run_d;
  logic [PROD_W-1:0] prod_d;
  logic [VT_W:0]     vt_sum;
  logic [VT_W-1:0]   vt_new;
  logic [TW-1:0]     left_new, now_new, ta, wt;
  logic [TW:0]       now_sum, tick_sum;
  logic              fin;
  out_t              res_scan, res_add;

  assign quantum  = (slice_q == '0) ? TW'(1) : slice_q;
  assign run_d    = (best_q.left < quantum) ? best_q.left : quantum;
  assign prod_d   = PROD_W'(run_d) * PROD_W'(best_q.wgt);
  assign vt_sum   = {1'b0, best_q.vt} + (VT_W + 1)'(prod_q);
  assign vt_new   = vt_sum[VT_W] ? VT_MAX : vt_sum[VT_W-1:0];
  assign left_new = best_q.left - run_q;
  assign now_sum  = {1'b0, now_q} + {1'b0, run_q};
  assign now_new  = now_sum[TW] ? '1 : now_sum[TW-1:0];
  assign tick_sum = {1'b0, now_q} + (TW + 1)'(1);
  assign ta       = now_new - best_q.arrival;
  assign wt       = (ta >= best_q.burst) ? ta - best_q.burst : '0;
  assign fin      = (left_new == '0);

  always_comb begin
    wb       = '0;
    wb.en    = (state_q == S_ADD);
    wb.idx   = best_q.idx;
    wb.left  = left_new;
    wb.vt    = vt_new;
    wb.fin   = fin;
    wb.order = counter_q;
  end

  // result at the end of a pass: admit outcome or idle tick
  always_comb begin
    res_scan = '0;
    if (item_q.opcode == OP_ADMIT) begin
      res_scan.status   = tok[MAX_PROCS].has ? ST_ADMIT : ST_FULL;
      res_scan.all_done = !tok[MAX_PROCS].has && (used_cnt_q == '0);
    end else begin
      res_scan.status   = ST_IDLE;
      res_scan.all_done = (used_cnt_q == '0);
    end
  end

  // result of a dispatched slice
  always_comb begin
    res_add            = '0;
    res_add.status     = fin ? ST_FINISH : ST_RUN;
    res_add.chosen_id  = best_q.id;
    res_add.start_time = now_q;
    res_add.run_length = run_q;
    res_add.left_after = left_new;
    res_add.turnaround = fin ? ta : '0;
    res_add.ready_wait = fin ? wt : '0;
    res_add.all_done   = fin && (used_cnt_q == UCW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slice_q     <= SLICE_RST;
      now_q       <= '0;
      counter_q   <= '0;
      used_cnt_q  <= '0;
      inj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // launch a pass straight after a schedule item or a finished division
      inj_q <= (accept && (in_data_i.opcode == OP_SCHED)) ||
               ((state_q == S_DIV) && div_done);
      if (cfg_we_i) begin
        slice_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.opcode == OP_ADMIT) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pass_end) begin
            if (item_q.opcode == OP_ADMIT) begin
              if (tok[MAX_PROCS].has) begin
                used_cnt_q <= used_cnt_q + 1'b1;
              end
              state_q <= S_FIN;
            end else begin
              // arrivals took their sequence numbers along the row
              counter_q <= tok[MAX_PROCS].cnt;
              if (tok[MAX_PROCS].has) begin
                state_q <= S_MUL;
              end else begin
                now_q   <= tick_sum[TW] ? '1 : tick_sum[TW-1:0];
                state_q <= S_FIN;
              end
            end
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          now_q <= now_new;
          if (fin) begin
            used_cnt_q <= used_cnt_q - 1'b1;
          end else begin
            counter_q <= counter_q + 1'b1;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (div_done) begin
      wgt_q <= div_quot;
    end
    if (state_q == S_SCAN && pass_end) begin
      best_q <= tok[MAX_PROCS];
      res_q  <= res_scan;
    end
    if (state_q == S_MUL) begin
      run_q  <= run_d;
      prod_q <= prod_d;
    end
    if (state_q == S_ADD) begin
      res_q <= res_add;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a token leaves the row only while a pass is in progress
  a_pass_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_end |-> state_q == S_SCAN)
    else $error("token left the row outside a pass");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= UCW'(MAX_PROCS))
    else $error("occupancy count beyond table size");

  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD && fin) |=> used_cnt_q == $past(used_cnt_q) - 1'b1)
    else $error("finished process did not free its slot");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result presented without completing an item");

endmodule
`default_nettype wire

// ----- tb/tb_weighted_fair_slice_scheduler.sv -----
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the weighted fair slice scheduler. A behavioural copy
// of the process table runs alongside the block: every accepted item updates
// it and pushes the result it should cause; a monitor compares each accepted
// result with the oldest expectation, field by field.
module tb_weighted_fair_slice_scheduler;
  import wfss_pkg::*;

  localparam int NSLOT    = int'(MAX_PROCS_DEF);
  localparam int FRAC     = int'(FRAC_BITS_DEF);
  localparam int IDLE_LIM = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  weighted_fair_slice_scheduler i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  // mirror of the process table
  bit          p_used  [NSLOT];
  bit          p_ready [NSLOT];
  bit [15:0]   p_id    [NSLOT];
  bit [15:0]   p_left  [NSLOT];
  bit [15:0]   p_burst [NSLOT];
  bit [15:0]   p_arr   [NSLOT];
  bit [63:0]   p_wgt   [NSLOT];
  bit [47:0]   p_vrt   [NSLOT];
  bit [31:0]   p_seq   [NSLOT];
  bit [15:0]   clock_now;
  bit [31:0]   seq_next;
  bit [15:0]   slice_len;

  out_t expected_q[$];
  int   fail_count;
  int   send_idle_pct, recv_stall_pct;
  int   quiet_cycles;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic bit [15:0] sat_add(input bit [15:0] t, input bit [31:0] d);
    bit [31:0] s;
    s = 32'(t) + d;
    return (s > 32'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  // advance the mirror by one item and return the result it must cause
  function automatic out_t schedule_predict(input in_t it);
    out_t r;
    int   slot, pick;
    bit [15:0] q, run, ta;
    bit [63:0] inc, vt;
    r = '0;
    slot = -1;
    pick = -1;
    if (it.opcode == OP_ADMIT) begin
      for (int i = NSLOT - 1; i >= 0; i--) if (!p_used[i]) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        p_used[slot]  = 1'b1;
        p_ready[slot] = 1'b0;
        p_id[slot]    = it.proc_id;
        p_burst[slot] = it.burst_time;
        p_left[slot]  = it.burst_time;
        p_arr[slot]   = it.arrival_time;
        p_wgt[slot]   = (64'd100 << FRAC) /
                        ((it.weight_priority == 0) ? 64'd1 : 64'(it.weight_priority));
        p_vrt[slot]   = '0;
        p_seq[slot]   = '0;
        r.status = ST_ADMIT;
      end
    end else begin
      for (int i = 0; i < NSLOT; i++)
        if (p_used[i] && !p_ready[i] && p_arr[i] <= clock_now) begin
          p_ready[i] = 1'b1;
          p_seq[i] = seq_next++;
        end
      for (int i = 0; i < NSLOT; i++) begin
        if (!p_used[i] || !p_ready[i]) continue;
        if (pick < 0 || p_vrt[i] < p_vrt[pick] ||
            (p_vrt[i] == p_vrt[pick] && p_seq[i] < p_seq[pick])) pick = i;
      end
      if (pick < 0) begin
        clock_now = sat_add(clock_now, 32'd1);
        r.status = ST_IDLE;
      end else begin
        q   = (slice_len == 0) ? 16'd1 : slice_len;
        run = (p_left[pick] < q) ? p_left[pick] : q;
        inc = 64'(run) * p_wgt[pick];
        vt  = 64'(p_vrt[pick]) + inc;
        r.chosen_id  = p_id[pick];
        r.start_time = clock_now;
        r.run_length = run;
        p_left[pick] = p_left[pick] - run;
        r.left_after = p_left[pick];
        clock_now    = sat_add(clock_now, 32'(run));
        p_vrt[pick]  = (vt > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : vt[47:0];
        if (p_left[pick] == 0) begin
          ta = clock_now - p_arr[pick];
          r.status     = ST_FINISH;
          r.turnaround = ta;
          r.ready_wait = (ta >= p_burst[pick]) ? ta - p_burst[pick] : 16'd0;
          p_used[pick]  = 1'b0;
          p_ready[pick] = 1'b0;
        end else begin
          r.status = ST_RUN;
          p_seq[pick] = seq_next++;
        end
      end
    end
    r.all_done = 1'b1;
    for (int i = 0; i < NSLOT; i++) if (p_used[i]) r.all_done = 1'b0;
    return r;
  endfunction

  // hold valid and payload until the item is taken, then drop valid
  task automatic send_item(input in_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(schedule_predict(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_t admit_item(input bit [15:0] id, input bit [15:0] burst,
                                     input bit [15:0] arr, input bit [9:0] prio);
    in_t it;
    it.opcode = OP_ADMIT;
    it.proc_id = id;
    it.burst_time = burst;
    it.arrival_time = arr;
    it.weight_priority = prio;
    return it;
  endfunction

  function automatic in_t sched_item();
    in_t it;
    it = in_t'($bits(in_t)'({$urandom, $urandom}));
    it.opcode = OP_SCHED;
    return it;
  endfunction

  // drain and let the block settle before touching the register
  task automatic write_slice(input bit [15:0] v);
    wait (expected_q.size() == 0);
    repeat (60) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    slice_len = v;
  endtask

  // receive side: random back-pressure, compare on acceptance
  always @(negedge clk_i)
    out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_data_o.status     !== w.status)
          report("status", 32'(out_data_o.status), 32'(w.status));
        if (out_data_o.chosen_id  !== w.chosen_id)
          report("chosen_id", 32'(out_data_o.chosen_id), 32'(w.chosen_id));
        if (out_data_o.start_time !== w.start_time)
          report("start_time", 32'(out_data_o.start_time), 32'(w.start_time));
        if (out_data_o.run_length !== w.run_length)
          report("run_length", 32'(out_data_o.run_length), 32'(w.run_length));
        if (out_data_o.left_after !== w.left_after)
          report("left_after", 32'(out_data_o.left_after), 32'(w.left_after));
        if (out_data_o.turnaround !== w.turnaround)
          report("turnaround", 32'(out_data_o.turnaround), 32'(w.turnaround));
        if (out_data_o.ready_wait !== w.ready_wait)
          report("ready_wait", 32'(out_data_o.ready_wait), 32'(w.ready_wait));
        if (out_data_o.all_done   !== w.all_done)
          report("all_done", 32'(out_data_o.all_done), 32'(w.all_done));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIM) begin
      $display("weighted_fair_slice_scheduler regression: fail");
      $finish;
    end
  end

  // extremes of each field, empty table, zero burst and zero priority, full table
  task automatic test_directed();
    send_item(sched_item());
    send_item(admit_item(16'hFFFF, 16'd0, 16'd0, 10'd0));
    send_item(admit_item(16'h0000, 16'hFFFF, 16'hFFFF, 10'h3FF));
    send_item(admit_item(16'h5A5A, 16'd25, 16'd3, 10'd1));
    for (int i = 0; i < 14; i++)
      send_item(admit_item(16'(i + 100), 16'(i + 1), 16'd0, 10'(i * 73)));
    repeat (6) send_item(sched_item());
  endtask

  // mostly well-formed: admit a few, then schedule three times as many plus two
  task automatic test_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int k;
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
        bit [15:0] b, a;
        b = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        a = ($urandom_range(9) == 0) ? 16'($urandom) : clock_now + 16'($urandom_range(0, 20));
        send_item(admit_item(16'($urandom), b, a, 10'($urandom)));
        sent++;
      end
      for (int i = 0; i < 3 * k + 2 && sent < n_items; i++) begin
        send_item(sched_item());
        sent++;
      end
    end
  endtask

  // step the clock through saturation so ready wait clamps at zero
  task automatic test_saturation();
    send_item(admit_item(16'h7777, 16'd40000, 16'd0, 10'd512));
    send_item(admit_item(16'h8888, 16'd40000, 16'd0, 10'd3));
    repeat (6) send_item(sched_item());
  endtask

  initial begin
    ref_clear();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 0; recv_stall_pct = 0;
    test_directed();
    write_slice(16'd0);
    test_random(120);
    // hold off until everything outstanding has arrived
    wait (expected_q.size() == 0);
    write_slice(16'd1);
    send_idle_pct = 70;
    test_random(150);
    write_slice(16'hFFFF);
    send_idle_pct = 0; recv_stall_pct = 70;
    test_random(150);
    write_slice(16'd30000);
    test_saturation();
    write_slice(16'd7);
    send_idle_pct = 26; recv_stall_pct = 26;
    test_random(200);

    wait (expected_q.size() == 0);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("weighted_fair_slice_scheduler regression: pass");
    else $display("weighted_fair_slice_scheduler regression: fail");
    $finish;
  end

  task automatic ref_clear();
    for (int i = 0; i < NSLOT; i++) begin
      p_used[i] = 1'b0;
      p_ready[i] = 1'b0;
    end
    clock_now = '0;
    seq_next = '0;
    slice_len = SLICE_RST;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

endmodule
`default_nettype wire
